>>> rtl/rsd_pkg.sv
// ----------------------------------------------------------------------------
// rsd_pkg
// Shared types and constants of the run-length scanline decoder.
// ----------------------------------------------------------------------------
package rsd_pkg;

    localparam int CFG_W       = 13;
    localparam int CFG_INDEX_W = 2;
    localparam int BYTE_W      = 8;
    localparam int RUN_LEN_W   = 6;
    localparam int FLAG_W      = 3;

    localparam logic [CFG_INDEX_W-1:0] REG_LINE_WIDTH = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_LINE_TOTAL = 2'd1;

    localparam logic [CFG_W-1:0] LINE_WIDTH_RESET = 13'd640;
    localparam logic [CFG_W-1:0] LINE_TOTAL_RESET = 13'd480;

    localparam logic [1:0] HEADER_MARK = 2'b11;

    typedef struct packed {
        logic take;
        logic emit;
    } rsd_cmd_t;

    typedef struct packed {
        logic out_free;
        logic run_multi;
        logic remain_one;
    } rsd_status_t;

endpackage

>>> rtl/rsd_ctrl.sv
// ----------------------------------------------------------------------------
// rsd_ctrl
// Sequencer that takes input bytes and holds the input while a run is emitted.
// ----------------------------------------------------------------------------
module rsd_ctrl
    import rsd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  rsd_status_t status,
    output rsd_cmd_t    cmd
);

    typedef enum logic [0:0] {
        S_TAKE,
        S_RUN
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next    = state_reg;
        s_axis_tready = 1'b0;
        cmd.take      = 1'b0;
        cmd.emit      = 1'b0;
        case (state_reg)
            S_TAKE:
            begin
                s_axis_tready = status.out_free;
                cmd.take      = s_axis_tvalid && status.out_free;
                if (cmd.take && status.run_multi)
                begin
                    state_next = S_RUN;
                end
            end
            S_RUN:
            begin
                cmd.emit = status.out_free;
                if (cmd.emit && status.remain_one)
                begin
                    state_next = S_TAKE;
                end
            end
            default:
            begin
                state_next = S_TAKE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_TAKE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

>>> rtl/rsd_datapath.sv
// ----------------------------------------------------------------------------
// rsd_datapath
// Configuration, run and line counters, and the output register.
// ----------------------------------------------------------------------------
module rsd_datapath
    import rsd_pkg::*;
#(
    parameter int MAX_WIDTH = 4096,
    parameter int MAX_LINES = 4096
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]       cfg_data,
    input  logic [BYTE_W-1:0]      s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [BYTE_W-1:0]      m_axis_tdata,
    output logic                   m_axis_tlast,
    output logic [FLAG_W-1:0]      m_axis_tuser,
    input  rsd_cmd_t               cmd,
    output rsd_status_t            status
);

    localparam int FILL_W  = $clog2(MAX_WIDTH + 1);
    localparam int LINE_W  = $clog2(MAX_LINES + 1);
    localparam int CMP_W   = ((FILL_W > CFG_W) ? FILL_W : CFG_W) + 1;
    localparam int LCMP_W  = ((LINE_W > CFG_W) ? LINE_W : CFG_W) + 1;

    logic [CFG_W-1:0]     line_width_reg, line_width_next;
    logic [CFG_W-1:0]     line_total_reg, line_total_next;
    logic                 awaiting_reg, awaiting_next;
    logic [RUN_LEN_W-1:0] pending_reg, pending_next;
    logic [FILL_W-1:0]    fill_reg, fill_next;
    logic [LINE_W-1:0]    line_reg, line_next;
    logic [RUN_LEN_W-1:0] remain_reg, remain_next;
    logic                 out_valid_reg, out_valid_next;

    logic [BYTE_W-1:0]    value_reg, value_next;
    logic                 end_f_reg, end_f_next;
    logic                 img_f_reg, img_f_next;
    logic                 ovr_f_reg, ovr_f_next;
    logic [BYTE_W-1:0]    out_data_reg, out_data_next;
    logic                 out_last_reg, out_last_next;
    logic [FLAG_W-1:0]    out_user_reg, out_user_next;

    logic                 is_header;
    logic                 pixel_in;
    logic [RUN_LEN_W-1:0] count;
    logic [CMP_W-1:0]     width_cfg, width_eff, total;
    logic [LCMP_W-1:0]    lines_cfg, lines_eff, line_inc;
    logic                 ends, overrun, last_line, first_last;

    assign is_header = (s_axis_tdata[BYTE_W-1 -: 2] == HEADER_MARK);
    assign count     = awaiting_reg ? pending_reg : RUN_LEN_W'(1);
    assign pixel_in  = cmd.take && (awaiting_reg ? (pending_reg != '0) : !is_header);

    assign width_cfg = CMP_W'(line_width_reg);
    assign width_eff = (width_cfg > CMP_W'(MAX_WIDTH)) ? CMP_W'(MAX_WIDTH) : width_cfg;
    assign lines_cfg = LCMP_W'(line_total_reg);

    always_comb
    begin
        lines_eff = (lines_cfg > LCMP_W'(MAX_LINES)) ? LCMP_W'(MAX_LINES) : lines_cfg;
        if (lines_eff == '0)
        begin
            lines_eff = LCMP_W'(1);
        end
    end

    assign total      = CMP_W'(fill_reg) + CMP_W'(count);
    assign ends       = (total >= width_eff);
    assign overrun    = (total > width_eff);
    assign line_inc   = LCMP_W'(line_reg) + LCMP_W'(1);
    assign last_line  = ends && (line_inc >= lines_eff);
    assign first_last = (count == RUN_LEN_W'(1));

    assign status.out_free   = !out_valid_reg || m_axis_tready;
    assign status.run_multi  = awaiting_reg && (pending_reg > RUN_LEN_W'(1));
    assign status.remain_one = (remain_reg == RUN_LEN_W'(1));

    always_comb
    begin
        line_width_next = line_width_reg;
        line_total_next = line_total_reg;
        awaiting_next   = awaiting_reg;
        pending_next    = pending_reg;
        fill_next       = fill_reg;
        line_next       = line_reg;
        remain_next     = remain_reg;
        out_valid_next  = out_valid_reg;
        value_next      = value_reg;
        end_f_next      = end_f_reg;
        img_f_next      = img_f_reg;
        ovr_f_next      = ovr_f_reg;
        out_data_next   = out_data_reg;
        out_last_next   = out_last_reg;
        out_user_next   = out_user_reg;

        if (cfg_we)
        begin
            case (cfg_index)
                REG_LINE_WIDTH: line_width_next = cfg_data;
                REG_LINE_TOTAL: line_total_next = cfg_data;
                default:        ;
            endcase
        end

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        if (cmd.take)
        begin
            if (awaiting_reg)
            begin
                awaiting_next = 1'b0;
                pending_next  = '0;
            end
            else if (is_header)
            begin
                awaiting_next = 1'b1;
                pending_next  = s_axis_tdata[RUN_LEN_W-1:0];
            end
        end

        if (pixel_in)
        begin
            value_next     = s_axis_tdata;
            end_f_next     = ends;
            img_f_next     = last_line;
            ovr_f_next     = overrun;
            remain_next    = count - RUN_LEN_W'(1);
            out_valid_next = 1'b1;
            out_data_next  = s_axis_tdata;
            out_last_next  = first_last;
            out_user_next  = {overrun && first_last, last_line && first_last,
                              ends && first_last};
            if (ends)
            begin
                fill_next = '0;
                line_next = last_line ? '0 : LINE_W'(line_inc);
            end
            else
            begin
                fill_next = FILL_W'(total);
            end
        end
        else if (cmd.emit)
        begin
            remain_next    = remain_reg - RUN_LEN_W'(1);
            out_valid_next = 1'b1;
            out_data_next  = value_reg;
            out_last_next  = status.remain_one;
            out_user_next  = {ovr_f_reg && status.remain_one,
                              img_f_reg && status.remain_one,
                              end_f_reg && status.remain_one};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_width_reg <= LINE_WIDTH_RESET;
            line_total_reg <= LINE_TOTAL_RESET;
            awaiting_reg   <= 1'b0;
            pending_reg    <= '0;
            fill_reg       <= '0;
            line_reg       <= '0;
            remain_reg     <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            line_width_reg <= line_width_next;
            line_total_reg <= line_total_next;
            awaiting_reg   <= awaiting_next;
            pending_reg    <= pending_next;
            fill_reg       <= fill_next;
            line_reg       <= line_next;
            remain_reg     <= remain_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg    <= value_next;
        end_f_reg    <= end_f_next;
        img_f_reg    <= img_f_next;
        ovr_f_reg    <= ovr_f_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
        out_user_reg <= out_user_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tuser  = out_user_reg;

endmodule

>>> rtl/rle_scanline_decoder_unit.sv
// ----------------------------------------------------------------------------
// rle_scanline_decoder_unit
// Run-length scanline decoder: code bytes in, decoded pixels out.
//
//   Channel   Role     Contents
//   s_axis    input    code byte
//   m_axis    output   pixel, last pixel of the byte, line and image flags
//   cfg       write    line width (index 0), line total (index 1)
//
// A literal byte, a run header or a zero-length run value is accepted on
// its own. A run value byte of length n is accepted and then keeps the
// input stalled while its n pixels leave the output register one a cycle,
// unless the output stalls. Reset restores the geometry defaults and
// clears the counters and the output valid flag; no sweep is needed. A
// stalled output holds its pixel and blocks further transfers.
// ----------------------------------------------------------------------------
module rle_scanline_decoder_unit
    import rsd_pkg::*;
#(
    parameter int MAX_WIDTH = 4096,
    parameter int MAX_LINES = 4096
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]       cfg_data,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [BYTE_W-1:0]      s_axis_tdata,   // code_byte
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [BYTE_W-1:0]      m_axis_tdata,   // pixel_value
    output logic                   m_axis_tlast,
    output logic [FLAG_W-1:0]      m_axis_tuser    // line_end, image_end, line_overrun
);

    rsd_cmd_t    cmd;
    rsd_status_t status;

    rsd_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .status        (status),
        .cmd           (cmd)
    );

    rsd_datapath #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_LINES (MAX_LINES)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .cmd           (cmd),
        .status        (status)
    );

endmodule

>>> rtl/rsd_checker.sv
// ----------------------------------------------------------------------------
// rsd_checker
// Port-level checks of the decoder, attached to the top level by bind.
// ----------------------------------------------------------------------------
module rsd_checker
    import rsd_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   s_axis_tready,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [BYTE_W-1:0]      m_axis_tdata,
    input logic                   m_axis_tlast,
    input logic [FLAG_W-1:0]      m_axis_tuser
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)
            && $stable(m_axis_tuser))
        else $error("stalled output transfer changed");

    a_in_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
        else $error("input accepted while output is stalled");

    a_flags_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser != '0) |-> m_axis_tlast)
        else $error("line flag on a pixel that is not the last of its byte");

    a_flags_need_end: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser[1] || m_axis_tuser[2]) |-> m_axis_tuser[0])
        else $error("image end or overrun without line end");

endmodule

bind rle_scanline_decoder_unit rsd_checker u_rsd_checker (.*);

>>> dv/rsd_pixel_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rsd_pixel_checker
// Watches the code byte, pixel and register write channels of the
// run-length scanline decoder. It keeps its own copy of the decoder state
// and geometry, expands each accepted code byte into the pixels it should
// produce, and compares every pixel transfer field by field in order.
// ----------------------------------------------------------------------------
module rsd_pixel_checker
    import rsd_pkg::*;
#(
    parameter int MAX_WIDTH = 4096,
    parameter int MAX_LINES = 4096
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]       cfg_data,
    input  logic                   s_axis_tvalid,
    input  logic                   s_axis_tready,
    input  logic [BYTE_W-1:0]      s_axis_tdata,   // code_byte
    input  logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    input  logic [BYTE_W-1:0]      m_axis_tdata,   // pixel_value
    input  logic                   m_axis_tlast,
    input  logic [FLAG_W-1:0]      m_axis_tuser,   // line_end, image_end, line_overrun
    output int                     pending_pixels,
    output int                     mismatches
);

    typedef struct packed {
        logic [BYTE_W-1:0] pixel_value;
        logic              run_last;
        logic              line_end;
        logic              image_end;
        logic              line_overrun;
    } pixel_t;

    pixel_t               pixel_q[$];
    logic [CFG_W-1:0]     width_reg    = LINE_WIDTH_RESET;
    logic [CFG_W-1:0]     total_reg    = LINE_TOTAL_RESET;
    logic                 value_next   = 1'b0;
    logic [RUN_LEN_W-1:0] run_length   = '0;
    int unsigned          line_fill    = 0;
    int unsigned          line_number  = 0;
    int                   fail_total   = 0;
    int                   open_pixels  = 0;

    assign pending_pixels = open_pixels;
    assign mismatches     = fail_total;

    task automatic expand_code_byte(input logic [BYTE_W-1:0] code);
        int unsigned count;
        int unsigned width_eff;
        int unsigned lines_eff;
        int unsigned filled;
        int unsigned k;
        logic        ends;
        logic        last_line;
        pixel_t      px;
        count = 0;
        if (value_next)
        begin
            count      = 32'(run_length);
            value_next = 1'b0;
            run_length = '0;
        end
        else if (code[BYTE_W-1 -: 2] == HEADER_MARK)
        begin
            value_next = 1'b1;
            run_length = code[RUN_LEN_W-1:0];
        end
        else
        begin
            count = 1;
        end
        if (count != 0)
        begin
            width_eff = (32'(width_reg) > MAX_WIDTH) ? MAX_WIDTH : 32'(width_reg);
            lines_eff = (32'(total_reg) > MAX_LINES) ? MAX_LINES : 32'(total_reg);
            if (lines_eff == 0)
                lines_eff = 1;
            filled    = line_fill + count;
            ends      = (filled >= width_eff);
            last_line = ends && (line_number + 1 >= lines_eff);
            for (k = 1; k <= count; k++)
            begin
                px.pixel_value  = code;
                px.run_last     = (k == count);
                px.line_end     = px.run_last && ends;
                px.image_end    = px.run_last && last_line;
                px.line_overrun = px.line_end && (filled > width_eff);
                pixel_q.push_back(px);
            end
            if (ends)
            begin
                line_fill   = 0;
                line_number = last_line ? 0 : line_number + 1;
            end
            else
            begin
                line_fill = filled;
            end
        end
    endtask

    task automatic check_field(input string field, input int expected, input int actual);
        if (expected != actual)
        begin
            $error("%s: expected %0d, actual %0d", field, expected, actual);
            fail_total++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        pixel_t px;
        if (!rst_n)
        begin
            width_reg   = LINE_WIDTH_RESET;
            total_reg   = LINE_TOTAL_RESET;
            value_next  = 1'b0;
            run_length  = '0;
            line_fill   = 0;
            line_number = 0;
            pixel_q.delete();
            open_pixels = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == REG_LINE_WIDTH)
                    width_reg = cfg_data;
                else if (cfg_index == REG_LINE_TOTAL)
                    total_reg = cfg_data;
            end
            if (s_axis_tvalid && s_axis_tready)
                expand_code_byte(s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (pixel_q.size() == 0)
                begin
                    $error("pixel transfer with no pixel expected: value %0d", m_axis_tdata);
                    fail_total++;
                end
                else
                begin
                    px = pixel_q.pop_front();
                    check_field("pixel_value", 32'(px.pixel_value), 32'(m_axis_tdata));
                    check_field("run_last", 32'(px.run_last), 32'(m_axis_tlast));
                    check_field("line_end", 32'(px.line_end), 32'(m_axis_tuser[0]));
                    check_field("image_end", 32'(px.image_end), 32'(m_axis_tuser[1]));
                    check_field("line_overrun", 32'(px.line_overrun),
                                32'(m_axis_tuser[2]));
                end
            end
            open_pixels = pixel_q.size();
        end
    end

endmodule

>>> dv/rle_scanline_decoder_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rle_scanline_decoder_unit_tb
// Drives code bytes into the run-length scanline decoder under several line
// geometries: a directed opening on literals, run lengths and odd widths,
// then random streams of literals, runs and loose bytes with random gaps and
// output stalls, one long output stall, and a final phase at full rate.
// ----------------------------------------------------------------------------
module rle_scanline_decoder_unit_tb;
    import rsd_pkg::*;

    localparam int MAX_WIDTH        = 4096;
    localparam int MAX_LINES        = 4096;
    localparam int SETTLE_CYCLES    = 8;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int PHASE_BYTES      = 34;
    localparam int PHASE_COUNT      = 6;

    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_B = 2'd3;

    logic                   clk;
    logic                   rst_n         = 1'b0;
    logic                   cfg_we        = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index     = '0;
    logic [CFG_W-1:0]       cfg_data      = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [BYTE_W-1:0]      s_axis_tdata  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [BYTE_W-1:0]      m_axis_tdata;
    logic                   m_axis_tlast;
    logic [FLAG_W-1:0]      m_axis_tuser;

    int pending_pixels;
    int mismatches;
    int bytes_sent    = 0;
    bit quiet         = 1'b0;
    bit long_hold_req = 1'b0;

    rle_scanline_decoder_unit #(
        .MAX_WIDTH(MAX_WIDTH),
        .MAX_LINES(MAX_LINES)
    ) DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    rsd_pixel_checker #(
        .MAX_WIDTH(MAX_WIDTH),
        .MAX_LINES(MAX_LINES)
    ) checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .m_axis_tlast   (m_axis_tlast),
        .m_axis_tuser   (m_axis_tuser),
        .pending_pixels (pending_pixels),
        .mismatches     (mismatches)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // The pixel side; one long stall lets the decoder back up into its input.
    initial
    begin
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge clk);
            end
            else if (!quiet && $urandom_range(0, 2) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge clk);
        end
    end

    task automatic send_byte(input logic [BYTE_W-1:0] code);
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= code;
        do
            @(posedge clk);
        while (!s_axis_tready);
        bytes_sent++;
    endtask

    task automatic send_run(input logic [RUN_LEN_W-1:0] run_len, input logic [BYTE_W-1:0] value);
        send_byte({HEADER_MARK, run_len});
        send_byte(value);
    endtask

    task automatic send_random_item();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick < 9)
            send_byte(BYTE_W'($urandom_range(0, 8'hBF)));
        else if (pick < 15)
            send_run(RUN_LEN_W'($urandom_range(1, 12)), BYTE_W'($urandom_range(0, 255)));
        else if (pick < 17)
            send_run(RUN_LEN_W'($urandom_range(13, 63)), BYTE_W'($urandom_range(0, 255)));
        else if (pick < 18)
            send_run('0, BYTE_W'($urandom_range(0, 255)));
        else
            send_byte(BYTE_W'($urandom_range(0, 255)));
    endtask

    // Registers change only once every pixel is out and the pipe is quiet.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_pixels != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] reg_index,
                             input logic [CFG_W-1:0] reg_value);
        cfg_we    <= 1'b1;
        cfg_index <= reg_index;
        cfg_data  <= reg_value;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_geometry(input logic [CFG_W-1:0] width, input logic [CFG_W-1:0] total);
        write_reg(REG_LINE_WIDTH, width);
        write_reg(REG_LINE_TOTAL, total);
    endtask

    initial
    begin
        int phase;
        int target;
        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_byte(8'h00);
        send_byte(8'hBF);
        send_byte(8'h7F);
        send_byte(8'h40);
        send_run(6'd0, 8'hAA);
        send_run(6'd1, 8'hFF);
        send_run(6'd63, 8'hC3);
        send_run(6'd5, 8'h00);
        settle();

        // Indexes with no register behind them must change nothing.
        write_reg(REG_SPARE_A, '1);
        write_reg(REG_SPARE_B, 13'h0A5A);
        set_geometry('0, '0);
        send_byte(8'h12);
        send_run(6'd3, 8'h55);
        send_run(6'd0, 8'h01);
        settle();

        set_geometry('1, '1);
        send_run(6'd7, 8'h80);
        settle();

        // The line is already past the new width when it is written.
        set_geometry(13'd5, 13'd2);
        send_byte(8'h01);
        send_byte(8'h02);
        send_run(6'd4, 8'h33);
        settle();

        for (phase = 0; phase < PHASE_COUNT; phase++)
        begin
            case (phase)
                0: set_geometry(13'd1, 13'd1);
                1: set_geometry(CFG_W'($urandom_range(2, 40)), CFG_W'($urandom_range(1, 5)));
                2: set_geometry(CFG_W'(MAX_WIDTH), CFG_W'(MAX_LINES));
                3: set_geometry(CFG_W'($urandom_range(1, 24)), CFG_W'($urandom_range(1, 4)));
                4: set_geometry(CFG_W'($urandom_range(MAX_WIDTH + 1, 8191)), 13'd0);
                default: set_geometry(CFG_W'($urandom_range(1, 32)),
                                      CFG_W'($urandom_range(1, 8)));
            endcase
            if (phase == PHASE_COUNT - 1)
                quiet = 1'b1;
            target = bytes_sent + PHASE_BYTES;
            if (phase == 1)
            begin
                long_hold_req = 1'b1;
                send_run(6'd63, BYTE_W'($urandom_range(0, 255)));
            end
            while (bytes_sent < target)
                send_random_item();
            settle();
        end

        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
